FILE: hw/rtl/modexp_pkg.sv
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared constants, the multiplier operand select codes, and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package modexp_pkg;

  localparam int unsigned EXP_BITS = 30;
  localparam int unsigned CNT_W    = $clog2(EXP_BITS + 1);

  localparam logic [29:0] MOD  = 30'd1000000007;
  localparam logic [31:0] MOD2 = 32'd2000000014;
  localparam logic [30:0] MU   = 31'((64'd1 << 60) / 64'd1000000007);

  typedef enum logic [1:0] {
    OP_SQUARE = 2'd0,
    OP_BASE   = 2'd1,
    OP_EST    = 2'd2,
    OP_QP     = 2'd3
  } mul_op_t;

  typedef struct packed {
    logic    load;
    logic    mul_en;
    mul_op_t op;
    logic    reduce;
    logic    shift;
    logic    emit;
  } modexp_cmd_t;

  typedef struct packed {
    logic bit_set;
    logic last_bit;
    logic out_free;
  } modexp_sts_t;

endpackage

FILE: hw/rtl/modexp_dp.sv
// ----------------------------------------------------------------------------
// Modular exponentiation datapath
// Holds the base, exponent scan and accumulator, and one shared 32x32
// multiplier that forms each product and its Barrett reduction.
// ----------------------------------------------------------------------------
module modexp_dp (
  input  logic                     clk,
  input  logic                     rst,
  input  modexp_pkg::modexp_cmd_t  cmd,
  output modexp_pkg::modexp_sts_t  sts,
  input  logic [29:0]              base,
  input  logic [29:0]              exponent,
  output logic [29:0]              power,
  output logic                     res_valid,
  input  logic                     res_stall
);
  import modexp_pkg::*;

  logic [29:0]         base_r;
  logic [29:0]         acc;
  logic [EXP_BITS-1:0] e_scan;
  logic [CNT_W-1:0]    bits_left;
  logic [59:0]         prod;
  logic [63:0]         mul_q;
  logic [31:0]         mul_a;
  logic [31:0]         mul_b;
  logic [63:0]         mul_p;
  logic [31:0]         rem;
  logic [29:0]         rem_fix;
  logic [29:0]         base_red;

  assign base_red = (base >= MOD) ? base - MOD : base;

  always_comb begin
    unique case (cmd.op)
      OP_SQUARE: begin
        mul_a = {2'b00, acc};
        mul_b = {2'b00, acc};
      end
      OP_BASE: begin
        mul_a = {2'b00, acc};
        mul_b = {2'b00, base_r};
      end
      OP_EST: begin
        mul_a = {1'b0, prod[59:29]};
        mul_b = {1'b0, MU};
      end
      OP_QP: begin
        mul_a = {1'b0, mul_q[61:31]};
        mul_b = {2'b00, MOD};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // The Barrett remainder stays below three times the modulus.
  assign rem = prod[31:0] - mul_q[31:0];

  always_comb begin
    if (rem >= MOD2) begin
      rem_fix = 30'(rem - MOD2);
    end else if (rem >= 32'(MOD)) begin
      rem_fix = 30'(rem - 32'(MOD));
    end else begin
      rem_fix = rem[29:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_r <= base_red;
      acc    <= 30'd1;
      e_scan <= EXP_BITS'(exponent);
    end else begin
      if (cmd.reduce) begin
        acc <= rem_fix;
      end
      if (cmd.shift) begin
        e_scan <= e_scan << 1;
      end
    end
    if (cmd.mul_en) begin
      if (cmd.op == OP_SQUARE || cmd.op == OP_BASE) begin
        prod <= mul_p[59:0];
      end else begin
        mul_q <= mul_p;
      end
    end
    if (cmd.emit) begin
      power <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_left <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        bits_left <= CNT_W'(EXP_BITS);
      end else if (cmd.shift) begin
        bits_left <= bits_left - CNT_W'(1);
      end
      res_valid <= cmd.emit | (res_valid & res_stall);
    end
  end

  assign sts.bit_set  = e_scan[EXP_BITS-1];
  assign sts.last_bit = (bits_left == CNT_W'(1));
  assign sts.out_free = ~res_valid | ~res_stall;

endmodule

FILE: hw/rtl/modexp_ctrl.sv
// ----------------------------------------------------------------------------
// Modular exponentiation controller
// Steps through square and multiply for each exponent bit, each modular
// product in the PROD, EST, QP and RED states on the shared multiplier.
// ----------------------------------------------------------------------------
module modexp_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     arg_valid,
  output logic                     arg_stall,
  output modexp_pkg::modexp_cmd_t  cmd,
  input  modexp_pkg::modexp_sts_t  sts
);
  import modexp_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PROD = 6'b000010,
    S_EST  = 6'b000100,
    S_QP   = 6'b001000,
    S_RED  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   mult_phase;
  logic   mult_phase_next;

  always_comb begin
    state_next      = state;
    mult_phase_next = mult_phase;
    cmd             = '0;
    cmd.op          = OP_SQUARE;
    arg_stall       = 1'b1;
    unique case (state)
      S_IDLE: begin
        arg_stall = rst;
        if (arg_valid && !rst) begin
          cmd.load        = 1'b1;
          mult_phase_next = 1'b0;
          state_next      = S_PROD;
        end
      end
      S_PROD: begin
        cmd.mul_en = 1'b1;
        cmd.op     = mult_phase ? OP_BASE : OP_SQUARE;
        state_next = S_EST;
      end
      S_EST: begin
        cmd.mul_en = 1'b1;
        cmd.op     = OP_EST;
        state_next = S_QP;
      end
      S_QP: begin
        cmd.mul_en = 1'b1;
        cmd.op     = OP_QP;
        state_next = S_RED;
      end
      S_RED: begin
        cmd.reduce = 1'b1;
        if (!mult_phase && sts.bit_set) begin
          mult_phase_next = 1'b1;
          state_next      = S_PROD;
        end else begin
          cmd.shift       = 1'b1;
          mult_phase_next = 1'b0;
          state_next      = sts.last_bit ? S_DONE : S_PROD;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      mult_phase <= 1'b0;
    end else begin
      state      <= state_next;
      mult_phase <= mult_phase_next;
    end
  end

endmodule

FILE: hw/rtl/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// Modular exponentiation
// Raises a base to an exponent modulo 1000000007 by left-to-right binary
// square-and-multiply.
//
//   Channel  Word              Valid      Stall
//   arg      base, exponent    arg_valid  arg_stall
//   res      power             res_valid  res_stall
//
// Each modular product steps through the product, estimate, quotient and
// reduce states on the single shared 32x32 multiplier, once for the square
// of every exponent bit and once more for every set bit.
// A finished word waits in the output register while the next item runs.
// Reset returns the controller to idle and clears res_valid.
// ----------------------------------------------------------------------------
module modular_exponentiation (
  input  logic        clk,
  input  logic        rst,
  input  logic [29:0] base,
  input  logic [29:0] exponent,
  input  logic        arg_valid,
  output logic        arg_stall,
  output logic [29:0] power,
  output logic        res_valid,
  input  logic        res_stall
);
  import modexp_pkg::*;

  modexp_cmd_t cmd;
  modexp_sts_t sts;

  modexp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .arg_valid (arg_valid),
    .arg_stall (arg_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  modexp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .base      (base),
    .exponent  (exponent),
    .power     (power),
    .res_valid (res_valid),
    .res_stall (res_stall)
  );

endmodule

FILE: hw/rtl/modexp_checker.sv
// ----------------------------------------------------------------------------
// Modular exponentiation checker
// Port-level properties of the block, bound to the top level.
// ----------------------------------------------------------------------------
module modexp_checker (
  input logic        clk,
  input logic        rst,
  input logic        arg_valid,
  input logic        arg_stall,
  input logic [29:0] power,
  input logic        res_valid,
  input logic        res_stall
);
  import modexp_pkg::*;

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(power))
    else $error("stalled result word changed");

  a_res_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> power < MOD)
    else $error("result word not reduced");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    arg_valid && !arg_stall |=> arg_stall)
    else $error("second word taken while an item is in progress");

  a_idle_after_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> !arg_stall)
    else $error("block not ready after delivering a result");

endmodule

bind modular_exponentiation modexp_checker u_modexp_checker (
  .clk       (clk),
  .rst       (rst),
  .arg_valid (arg_valid),
  .arg_stall (arg_stall),
  .power     (power),
  .res_valid (res_valid),
  .res_stall (res_stall)
);
